FILE: hw/rtl/tno_pkg.sv
// ----------------------------------------------------------------------------
// tno_pkg: shared types and constants of the telnet option negotiator
// Byte codes, command codes that pass from the front end to the emitter,
// and the reply byte tables.
// ----------------------------------------------------------------------------
package tno_pkg;

  localparam int NAME_BYTES_DEF = 32;
  localparam int StoreDepth     = 32;
  localparam int MemAddrW       = $clog2(StoreDepth);
  localparam int NameLenW       = $clog2(StoreDepth + 1);
  localparam int QueueDepth     = 2;

  localparam logic [7:0] IAC        = 8'hFF;
  localparam logic [7:0] DONT       = 8'hFE;
  localparam logic [7:0] DO         = 8'hFD;
  localparam logic [7:0] WONT       = 8'hFC;
  localparam logic [7:0] WILL       = 8'hFB;
  localparam logic [7:0] SB         = 8'hFA;
  localparam logic [7:0] SE         = 8'hF0;
  localparam logic [7:0] IP         = 8'hF4;
  localparam logic [7:0] BRK        = 8'hF3;
  localparam logic [7:0] OPT_BINARY = 8'h00;
  localparam logic [7:0] OPT_TTYPE  = 8'h18;
  localparam logic [7:0] TT_IS      = 8'h00;
  localparam logic [7:0] TT_SEND    = 8'h01;

  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_DO_BIN   = 3'd1;
  localparam logic [2:0] CMD_WILL_BIN = 3'd2;
  localparam logic [2:0] CMD_DONT_BIN = 3'd3;
  localparam logic [2:0] CMD_WONT_BIN = 3'd4;
  localparam logic [2:0] CMD_TT_SEND  = 3'd5;
  localparam logic [2:0] CMD_NAME     = 3'd6;

  typedef struct packed {
    logic done;
    logic data_iac;
    logic brk;
    logic bin_in;
    logic bin_out;
  } status_t;

  typedef struct packed {
    logic [2:0]          code;
    logic [NameLenW-1:0] name_len;
    status_t             status;
  } cmd_t;

  typedef struct packed {
    logic                en;
    logic [MemAddrW-1:0] addr;
    logic [7:0]          data;
  } name_wr_t;

  function automatic logic [NameLenW-1:0] reply_len(input logic [2:0] code);
    logic [NameLenW-1:0] len;
    len = (code == CMD_TT_SEND) ? NameLenW'(6) : NameLenW'(3);
    return len;
  endfunction

  function automatic logic [7:0] reply_byte(input logic [2:0] code, input logic [2:0] idx);
    logic [7:0] verb;
    logic [7:0] b;
    unique case (code)
      CMD_DO_BIN:   verb = DO;
      CMD_WILL_BIN: verb = WILL;
      CMD_DONT_BIN: verb = DONT;
      CMD_WONT_BIN: verb = WONT;
      default:      verb = SB;
    endcase
    unique case (idx)
      3'd0:    b = IAC;
      3'd1:    b = verb;
      3'd2:    b = (code == CMD_TT_SEND) ? OPT_TTYPE : OPT_BINARY;
      3'd3:    b = TT_SEND;
      3'd4:    b = IAC;
      default: b = SE;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/tno_in_if.sv
// ----------------------------------------------------------------------------
// tno_in_if: received byte channel
// One beat carries the next byte of a sequence that followed IAC.
// ----------------------------------------------------------------------------
interface tno_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/tno_out_if.sv
// ----------------------------------------------------------------------------
// tno_out_if: result channel
// One beat carries a reply byte, a name byte or a bare status result.
// ----------------------------------------------------------------------------
interface tno_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       name_valid;
  logic [7:0] name_byte;
  logic       last;
  logic       done_res;
  logic       data_iac;
  logic       break_event;
  logic       binary_in;
  logic       binary_out;

  modport source (
    output valid, output tx_valid, output tx_byte, output name_valid, output name_byte,
    output last, output done_res, output data_iac, output break_event,
    output binary_in, output binary_out, input ready
  );
  modport sink (
    input valid, input tx_valid, input tx_byte, input name_valid, input name_byte,
    input last, input done_res, input data_iac, input break_event,
    input binary_in, input binary_out, output ready
  );
endinterface

FILE: hw/rtl/tno_front.sv
// ----------------------------------------------------------------------------
// tno_front: command parser
// Accepts bytes, tracks phase, modes and subnegotiation, writes name
// bytes and pushes one command per byte toward the emitter.
// ----------------------------------------------------------------------------
module tno_front
  import tno_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  tno_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd,
  output name_wr_t name_wr
);

  localparam int NameCap = (NAME_BYTES < StoreDepth) ? NAME_BYTES : StoreDepth;
  localparam logic [5:0] NameCapV = 6'(NameCap);

  localparam logic [2:0] PH_CMD  = 3'd0;
  localparam logic [2:0] PH_WILL = 3'd1;
  localparam logic [2:0] PH_DO   = 3'd2;
  localparam logic [2:0] PH_WONT = 3'd3;
  localparam logic [2:0] PH_DONT = 3'd4;
  localparam logic [2:0] PH_SUB  = 3'd5;

  logic [2:0]          phase_r, phase_nxt;
  logic                prev_iac_r, prev_iac_nxt;
  logic [5:0]          sub_count_r, sub_count_nxt;
  logic [7:0]          sub_first_r, sub_first_nxt;
  logic [7:0]          sub_second_r, sub_second_nxt;
  logic [5:0]          pending_r, pending_nxt;
  logic                nul_seen_r, nul_seen_nxt;
  logic [5:0]          clean_len_r, clean_len_nxt;
  logic                name_set_r, name_set_nxt;
  logic                mode_in_r, mode_in_nxt;
  logic                mode_out_r, mode_out_nxt;

  logic                fire;
  logic [7:0]          b;
  logic [5:0]          store_pos;
  logic                iac_stored;
  logic [5:0]          cap_len;
  logic                cap_ok;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && !q_full;
  assign b           = in_ch.rx_byte;
  assign q_push      = fire;

  assign store_pos  = sub_count_r - 6'd2;
  assign iac_stored = (sub_count_r >= 6'd3) && (pending_r != 6'd0) &&
                      (pending_r == store_pos);
  assign cap_len    = nul_seen_r ? clean_len_r : (pending_r - {5'd0, iac_stored});
  assign cap_ok     = !name_set_r && (sub_count_r >= 6'd3) && (sub_first_r == OPT_TTYPE) &&
                      (sub_second_r == TT_IS);

  always_comb begin
    phase_nxt      = phase_r;
    prev_iac_nxt   = prev_iac_r;
    sub_count_nxt  = sub_count_r;
    sub_first_nxt  = sub_first_r;
    sub_second_nxt = sub_second_r;
    pending_nxt    = pending_r;
    nul_seen_nxt   = nul_seen_r;
    clean_len_nxt  = clean_len_r;
    name_set_nxt   = name_set_r;
    mode_in_nxt    = mode_in_r;
    mode_out_nxt   = mode_out_r;
    q_cmd          = '0;
    q_cmd.code     = CMD_NONE;
    name_wr        = '0;
    name_wr.data   = b;
    if (fire) begin
      unique case (phase_r)
        PH_WILL, PH_DO, PH_WONT, PH_DONT: begin
          if (b == OPT_BINARY) begin
            unique case (phase_r)
              PH_WILL: begin
                mode_in_nxt = 1'b1;
                q_cmd.code  = CMD_DO_BIN;
              end
              PH_DO: begin
                mode_out_nxt = 1'b1;
                q_cmd.code   = CMD_WILL_BIN;
              end
              PH_WONT: begin
                mode_in_nxt = 1'b0;
                q_cmd.code  = CMD_DONT_BIN;
              end
              default: begin
                mode_out_nxt = 1'b0;
                q_cmd.code   = CMD_WONT_BIN;
              end
            endcase
          end else if (b == OPT_TTYPE && phase_r == PH_WILL) begin
            q_cmd.code = CMD_TT_SEND;
          end
          q_cmd.status.done = 1'b1;
          phase_nxt         = PH_CMD;
        end
        PH_SUB: begin
          if (prev_iac_r && b == SE) begin
            if (cap_ok) begin
              pending_nxt = cap_len;
              if (cap_len != 6'd0) begin
                name_set_nxt   = 1'b1;
                q_cmd.code     = CMD_NAME;
                q_cmd.name_len = NameLenW'(cap_len);
              end
            end else if (!name_set_r) begin
              pending_nxt = 6'd0;
            end
            q_cmd.status.done = 1'b1;
            phase_nxt         = PH_CMD;
            prev_iac_nxt      = 1'b0;
          end else begin
            if (sub_count_r == 6'd0) begin
              sub_first_nxt = b;
            end else if (sub_count_r == 6'd1) begin
              sub_second_nxt = b;
            end else if (!name_set_r && store_pos < NameCapV) begin
              name_wr.en   = 1'b1;
              name_wr.addr = store_pos[MemAddrW-1:0];
              pending_nxt  = sub_count_r - 6'd1;
              if (!nul_seen_r && b == 8'h00) begin
                nul_seen_nxt  = 1'b1;
                clean_len_nxt = store_pos;
              end
            end
            if (sub_count_r != 6'd63) begin
              sub_count_nxt = sub_count_r + 6'd1;
            end
            prev_iac_nxt = (b == IAC);
          end
        end
        default: begin
          phase_nxt = PH_CMD;
          priority case (b)
            IAC: begin
              q_cmd.status.data_iac = 1'b1;
              q_cmd.status.done     = 1'b1;
            end
            IP, BRK: begin
              q_cmd.status.brk  = 1'b1;
              q_cmd.status.done = 1'b1;
            end
            WILL: phase_nxt = PH_WILL;
            DO:   phase_nxt = PH_DO;
            WONT: phase_nxt = PH_WONT;
            DONT: phase_nxt = PH_DONT;
            SB: begin
              phase_nxt      = PH_SUB;
              sub_count_nxt  = 6'd0;
              prev_iac_nxt   = 1'b0;
              sub_first_nxt  = 8'h00;
              sub_second_nxt = 8'h00;
              nul_seen_nxt   = 1'b0;
              clean_len_nxt  = 6'd0;
              if (!name_set_r) begin
                pending_nxt = 6'd0;
              end
            end
            default: q_cmd.status.done = 1'b1;
          endcase
        end
      endcase
    end
    q_cmd.status.bin_in  = mode_in_nxt;
    q_cmd.status.bin_out = mode_out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_CMD;
      prev_iac_r   <= 1'b0;
      sub_count_r  <= 6'd0;
      sub_first_r  <= 8'h00;
      sub_second_r <= 8'h00;
      pending_r    <= 6'd0;
      nul_seen_r   <= 1'b0;
      clean_len_r  <= 6'd0;
      name_set_r   <= 1'b0;
      mode_in_r    <= 1'b0;
      mode_out_r   <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      prev_iac_r   <= prev_iac_nxt;
      sub_count_r  <= sub_count_nxt;
      sub_first_r  <= sub_first_nxt;
      sub_second_r <= sub_second_nxt;
      pending_r    <= pending_nxt;
      nul_seen_r   <= nul_seen_nxt;
      clean_len_r  <= clean_len_nxt;
      name_set_r   <= name_set_nxt;
      mode_in_r    <= mode_in_nxt;
      mode_out_r   <= mode_out_nxt;
    end
  end

endmodule

FILE: hw/rtl/tno_queue.sv
// ----------------------------------------------------------------------------
// tno_queue: command queue
// Small FIFO between parser and emitter; head stays until popped.
// ----------------------------------------------------------------------------
module tno_queue
  import tno_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head,
  input  logic pop
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_pop;

  assign full       = (count_r == CntW'(QueueDepth));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/tno_back.sv
// ----------------------------------------------------------------------------
// tno_back: result emitter
// Holds the name memory and expands each command into its beats: reply
// bytes from the tables, name bytes from memory, or one status beat.
// ----------------------------------------------------------------------------
module tno_back
  import tno_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  name_wr_t  name_wr,
  input  logic      head_valid,
  input  cmd_t      head,
  output logic      pop,
  tno_out_if.source out_ch
);

  localparam int NameCap = (NAME_BYTES < StoreDepth) ? NAME_BYTES : StoreDepth;
  localparam int AddrW   = (NameCap > 1) ? $clog2(NameCap) : 1;

  logic [7:0]          name_mem [NameCap];
  logic [7:0]          rd_data_r;
  logic [NameLenW-1:0] beat_idx_r;
  logic                out_valid_r;
  logic                tx_valid_r;
  logic [7:0]          tx_byte_r;
  logic                name_valid_r;
  logic                last_r;
  status_t             status_r;

  logic [NameLenW-1:0] total;
  logic                is_reply;
  logic                is_name;
  logic                is_last;
  logic                issue;

  assign is_name  = (head.code == CMD_NAME);
  assign is_reply = (head.code != CMD_NAME) && (head.code != CMD_NONE);

  always_comb begin
    priority if (is_name) begin
      total = head.name_len;
    end else if (is_reply) begin
      total = reply_len(head.code);
    end else begin
      total = NameLenW'(1);
    end
  end

  assign is_last = (beat_idx_r == total - 1'b1);
  assign issue   = head_valid && (!out_valid_r || out_ch.ready);
  assign pop     = issue && is_last;

  always_ff @(posedge clk) begin
    if (name_wr.en) begin
      name_mem[name_wr.addr[AddrW-1:0]] <= name_wr.data;
    end
    if (issue && is_name) begin
      rd_data_r <= name_mem[beat_idx_r[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_idx_r  <= '0;
    end else begin
      if (issue) begin
        out_valid_r <= 1'b1;
        beat_idx_r  <= is_last ? '0 : beat_idx_r + 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      tx_valid_r   <= is_reply;
      tx_byte_r    <= is_reply ? reply_byte(head.code, beat_idx_r[2:0]) : 8'h00;
      name_valid_r <= is_name;
      last_r       <= is_last;
      status_r     <= head.status;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tx_valid    = tx_valid_r;
  assign out_ch.tx_byte     = tx_byte_r;
  assign out_ch.name_valid  = name_valid_r;
  assign out_ch.name_byte   = name_valid_r ? rd_data_r : 8'h00;
  assign out_ch.last        = last_r;
  assign out_ch.done_res    = status_r.done;
  assign out_ch.data_iac    = status_r.data_iac;
  assign out_ch.break_event = status_r.brk;
  assign out_ch.binary_in   = status_r.bin_in;
  assign out_ch.binary_out  = status_r.bin_out;

endmodule

FILE: hw/rtl/telnet_option_negotiator_top.sv
// A byte's first result beat passes the command queue and the output register.
// Throughput: one byte per cycle into a two-entry command queue unless full;
// the emitter gives one beat per cycle unless held by out_ch.ready: 1, 3 or 6
// beats per byte, or one per name character (up to NAME_BYTES, at most 32).
// Reset: synchronous active-low, clears phase, modes and queue; name memory
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// telnet_option_negotiator_top: telnet option negotiator
// Parser front end, command queue and result emitter.
// ----------------------------------------------------------------------------
module telnet_option_negotiator_top
  import tno_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tno_in_if.sink    in_ch,
  tno_out_if.source out_ch
);

  logic     q_full;
  logic     q_push;
  cmd_t     q_cmd;
  name_wr_t name_wr;
  logic     head_valid;
  cmd_t     head;
  logic     pop;

  tno_front #(.NAME_BYTES(NAME_BYTES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .name_wr (name_wr)
  );

  tno_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  tno_back #(.NAME_BYTES(NAME_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .name_wr    (name_wr),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

FILE: hw/rtl/tno_checker.sv
// ----------------------------------------------------------------------------
// tno_checker: port-level checks
// Watches the result channel of the negotiator top level.
// ----------------------------------------------------------------------------
module tno_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       name_valid,
  input logic       last,
  input logic       done_res,
  input logic       data_iac,
  input logic       break_event,
  input logic       binary_in,
  input logic       binary_out
);

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last))
    else $error("result beat changed while stalled");

  // the next beat of the same byte follows at once with the same status
  a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=>
      out_valid && $stable(binary_in) && $stable(binary_out) && $stable(done_res))
    else $error("multi-beat result broke or changed status");

  a_run_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> (tx_valid || name_valid) && !data_iac && !break_event)
    else $error("status-only result spans beats");

  a_payload_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (tx_valid || name_valid) |-> done_res && !(tx_valid && name_valid))
    else $error("reply or name beat without finished sequence");

endmodule

bind telnet_option_negotiator_top tno_checker u_tno_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .tx_valid    (out_ch.tx_valid),
  .tx_byte     (out_ch.tx_byte),
  .name_valid  (out_ch.name_valid),
  .last        (out_ch.last),
  .done_res    (out_ch.done_res),
  .data_iac    (out_ch.data_iac),
  .break_event (out_ch.break_event),
  .binary_in   (out_ch.binary_in),
  .binary_out  (out_ch.binary_out)
);
